[src/slep_pkg.sv]
// ----------------------------------------------------------------------------
// slep_pkg
// shared constants, configuration layout and classification flags for the
// scan line edge picker
// ----------------------------------------------------------------------------
package slep_pkg;

    localparam int DEF_MAX_HALF_LENGTH = 8;
    localparam int DEF_MAX_LINE_NODES  = 1024;
    localparam int DEF_SAMPLE_BITS     = 12;

    localparam int STRENGTH_W  = 16;
    localparam int THRESH_W    = 8;
    localparam int HALF_W      = 4;
    localparam int LWIDTH_W    = 4;
    localparam int DEPTH_W     = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 3;

    localparam int GROUP_SIZE  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_FIRST   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALLING_EDGE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_LIMIT    = 3'd5;

    localparam logic [THRESH_W-1:0] RST_EDGE_THRESHOLD = 8'd20;
    localparam logic [HALF_W-1:0]   RST_HALF_LENGTH    = 4'd2;
    localparam logic [LWIDTH_W-1:0] RST_LINE_WIDTH     = 4'd3;
    localparam logic [DEPTH_W-1:0]  RST_DEPTH_LIMIT    = 8'd0;

    typedef struct packed {
        logic [THRESH_W-1:0] edge_threshold;
        logic                select_first;
        logic                falling_edge;
        logic [HALF_W-1:0]   half_length;
        logic [LWIDTH_W-1:0] line_width;
        logic [DEPTH_W-1:0]  depth_limit;
    } cfg_t;

    // classification of one queued transaction
    typedef struct packed {
        logic is_last;
        logic gt_s;
        logic ge_s;
        logic lt_negs;
        logic le_negs;
    } node_flags_t;

endpackage

[src/slep_if.sv]
// ----------------------------------------------------------------------------
// slep_in_if / slep_out_if
// valid/ready channels for profile samples and per-line results
// ----------------------------------------------------------------------------
interface slep_in_if
    import slep_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_sum;
    logic                   last_sample;

    modport source (output valid, output sample_sum, output last_sample, input ready);
    modport sink   (input valid, input sample_sum, input last_sample, output ready);
endinterface

interface slep_out_if
    import slep_pkg::*;
#(
    parameter int MAX_LINE_NODES = DEF_MAX_LINE_NODES
);
    localparam int IDX_W = $clog2(MAX_LINE_NODES);

    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [IDX_W-1:0]             edge_index;
    logic signed [STRENGTH_W-1:0] edge_strength;

    modport source (output valid, output found, output edge_index, output edge_strength,
                    input ready);
    modport sink   (input valid, input found, input edge_index, input edge_strength,
                    output ready);
endinterface

[src/scan_line_edge_picker_unit.sv]
// ----------------------------------------------------------------------------
// scan_line_edge_picker_unit
// box-difference edge picker for one scan line, one result per line
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   sample_sum, last_sample
//  results   out  valid/ready   found, edge_index, edge_strength
//  cfg       in   cfg_we        cfg_index, cfg_data
//
//  one sample transaction per cycle unless stalled; a node passes the front
//  pipeline (window, group sums, difference, compare) before it reaches the
//  queue, and the result leaves in the cycle after the last-sample marker is
//  dequeued. the result register holds until taken while samples of the
//  next line keep flowing; samples stall only when the four-entry queue
//  fills. reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module scan_line_edge_picker_unit
    import slep_pkg::*;
#(
    parameter int MAX_HALF_LENGTH = DEF_MAX_HALF_LENGTH,
    parameter int MAX_LINE_NODES  = DEF_MAX_LINE_NODES,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    slep_in_if.sink                samples,
    slep_out_if.source             results
);
    localparam int IDX_W   = $clog2(MAX_LINE_NODES);
    localparam int DW      = SAMPLE_BITS + $clog2(MAX_HALF_LENGTH + 1) + 1;
    localparam int FLAGS_W = $bits(node_flags_t);
    localparam int Q_W     = FLAGS_W + IDX_W + DW;

    cfg_t cfg_reg, cfg_next;

    logic                 push, queue_ready, take, entry_valid;
    node_flags_t          push_flags, entry_flags;
    logic [IDX_W-1:0]     push_index, entry_index;
    logic signed [DW-1:0] push_strength, entry_strength;
    logic [Q_W-1:0]       push_data, pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_THRESHOLD: cfg_next.edge_threshold = cfg_data[THRESH_W-1:0];
                CFG_SELECT_FIRST:   cfg_next.select_first   = cfg_data[0];
                CFG_FALLING_EDGE:   cfg_next.falling_edge   = cfg_data[0];
                CFG_HALF_LENGTH:    cfg_next.half_length    = cfg_data[HALF_W-1:0];
                CFG_LINE_WIDTH:     cfg_next.line_width     = cfg_data[LWIDTH_W-1:0];
                CFG_DEPTH_LIMIT:    cfg_next.depth_limit    = cfg_data[DEPTH_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_threshold <= RST_EDGE_THRESHOLD;
            cfg_reg.select_first   <= 1'b0;
            cfg_reg.falling_edge   <= 1'b0;
            cfg_reg.half_length    <= RST_HALF_LENGTH;
            cfg_reg.line_width     <= RST_LINE_WIDTH;
            cfg_reg.depth_limit    <= RST_DEPTH_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    slep_front #(
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH),
        .MAX_LINE_NODES  (MAX_LINE_NODES),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .samples       (samples),
        .push          (push),
        .push_flags    (push_flags),
        .push_index    (push_index),
        .push_strength (push_strength),
        .queue_ready   (queue_ready)
    );

    assign push_data = {push_flags, push_index, push_strength};

    slep_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (queue_ready),
        .pop        (take),
        .pop_data   (pop_data),
        .pop_valid  (entry_valid)
    );

    assign entry_flags    = node_flags_t'(pop_data[Q_W-1 -: FLAGS_W]);
    assign entry_index    = pop_data[DW +: IDX_W];
    assign entry_strength = signed'(pop_data[DW-1:0]);

    slep_back #(
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH),
        .MAX_LINE_NODES  (MAX_LINE_NODES),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .entry_valid    (entry_valid),
        .entry_flags    (entry_flags),
        .entry_index    (entry_index),
        .entry_strength (entry_strength),
        .take           (take),
        .results        (results)
    );

endmodule

[src/slep_fifo.sv]
// ----------------------------------------------------------------------------
// slep_fifo
// short register queue between the classifying front and the selecting back
// ----------------------------------------------------------------------------
module slep_fifo
    import slep_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/slep_front.sv]
// ----------------------------------------------------------------------------
// slep_front
// sample window, box-difference strength and threshold classification
// ----------------------------------------------------------------------------
module slep_front
    import slep_pkg::*;
#(
    parameter int MAX_HALF_LENGTH = DEF_MAX_HALF_LENGTH,
    parameter int MAX_LINE_NODES  = DEF_MAX_LINE_NODES,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    localparam int IDX_W          = $clog2(MAX_LINE_NODES),
    localparam int DW             = SAMPLE_BITS + $clog2(MAX_HALF_LENGTH + 1) + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    slep_in_if.sink              samples,
    output logic                 push,
    output node_flags_t          push_flags,
    output logic [IDX_W-1:0]     push_index,
    output logic signed [DW-1:0] push_strength,
    input  logic                 queue_ready
);
    localparam int WIN_DEPTH = 2 * MAX_HALF_LENGTH + 1;
    localparam int LEN_W     = $clog2(MAX_HALF_LENGTH + 1);
    localparam int CNT_W     = $clog2(MAX_LINE_NODES + 1);
    localparam int R_GROUPS  = (MAX_HALF_LENGTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int L_GROUPS  = (2 * MAX_HALF_LENGTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GW        = SAMPLE_BITS + $clog2(GROUP_SIZE + 1);
    localparam int SUM_W     = DW - 1;
    localparam int TW        = THRESH_W + LWIDTH_W;
    localparam int KW        = $clog2(2 * MAX_HALF_LENGTH + 2);
    localparam int SW        = TW + KW;
    localparam int CW        = ((DW > SW) ? DW : SW + 1) + 1;

    logic [SAMPLE_BITS-1:0] win_reg [WIN_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [TW-1:0]          tw_reg;
    logic [KW-1:0]          k_reg;
    logic [SW-1:0]          s_reg;

    logic [LEN_W-1:0]    len;
    logic [LWIDTH_W-1:0] wid;
    logic                stall, accept, in_range, is_node;
    logic [IDX_W-1:0]    node_index;

    logic             p1_valid_reg, p1_last_reg;
    logic [IDX_W-1:0] p1_index_reg;
    logic [LEN_W-1:0] p1_len_reg;

    logic             p2_valid_reg, p2_last_reg;
    logic [IDX_W-1:0] p2_index_reg;
    logic [GW-1:0]    p2_right_reg [R_GROUPS];
    logic [GW-1:0]    p2_left_reg  [L_GROUPS];

    logic                 p3_valid_reg, p3_last_reg;
    logic [IDX_W-1:0]     p3_index_reg;
    logic signed [DW-1:0] p3_d_reg;

    logic [SAMPLE_BITS-1:0] r_el [R_GROUPS * GROUP_SIZE];
    logic [SAMPLE_BITS-1:0] l_el [L_GROUPS * GROUP_SIZE];
    logic [GW-1:0]          r_grp [R_GROUPS];
    logic [GW-1:0]          l_grp [L_GROUPS];
    logic [SUM_W-1:0]       r_sum, l_sum;
    logic signed [DW-1:0]   d_next;
    logic signed [CW-1:0]   ds, ss, nss;

    assign stall         = p3_valid_reg && !queue_ready;
    assign samples.ready = !stall;
    assign accept        = samples.valid && !stall;

    always_comb
    begin
        if (int'(cfg.half_length) > MAX_HALF_LENGTH)
        begin
            len = LEN_W'(MAX_HALF_LENGTH);
        end
        else
        begin
            len = LEN_W'(cfg.half_length);
        end
        wid        = (cfg.line_width == '0) ? LWIDTH_W'(1) : cfg.line_width;
        in_range   = (count_reg < CNT_W'(MAX_LINE_NODES));
        is_node    = (len != '0) && (int'(count_reg) >= 2 * int'(len));
        node_index = IDX_W'(int'(count_reg) - int'(len));
    end

    // threshold scale, two registered products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= '0;
            k_reg  <= '0;
            s_reg  <= '0;
        end
        else
        begin
            tw_reg <= TW'(cfg.edge_threshold) * TW'(wid);
            k_reg  <= KW'(2 * int'(len) + 1);
            s_reg  <= SW'(tw_reg) * SW'(k_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (samples.last_sample)
            begin
                count_reg <= '0;
            end
            else if (in_range)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !samples.last_sample && in_range)
        begin
            win_reg[0] <= samples.sample_sum;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // masked group sums over the current window
    always_comb
    begin
        for (int k = 0; k < R_GROUPS * GROUP_SIZE; k++)
        begin
            r_el[k] = '0;
        end
        for (int k = 0; k < MAX_HALF_LENGTH; k++)
        begin
            if (k < int'(p1_len_reg))
            begin
                r_el[k] = win_reg[k];
            end
        end
        for (int e = 0; e < L_GROUPS * GROUP_SIZE; e++)
        begin
            l_el[e] = '0;
        end
        for (int e = 0; e < 2 * MAX_HALF_LENGTH; e++)
        begin
            if (e >= int'(p1_len_reg) && e < 2 * int'(p1_len_reg))
            begin
                l_el[e] = win_reg[e+1];
            end
        end
        for (int g = 0; g < R_GROUPS; g++)
        begin
            r_grp[g] = '0;
            for (int e = 0; e < GROUP_SIZE; e++)
            begin
                r_grp[g] = r_grp[g] + GW'(r_el[g * GROUP_SIZE + e]);
            end
        end
        for (int g = 0; g < L_GROUPS; g++)
        begin
            l_grp[g] = '0;
            for (int e = 0; e < GROUP_SIZE; e++)
            begin
                l_grp[g] = l_grp[g] + GW'(l_el[g * GROUP_SIZE + e]);
            end
        end
    end

    always_comb
    begin
        r_sum = '0;
        l_sum = '0;
        for (int g = 0; g < R_GROUPS; g++)
        begin
            r_sum = r_sum + SUM_W'(p2_right_reg[g]);
        end
        for (int g = 0; g < L_GROUPS; g++)
        begin
            l_sum = l_sum + SUM_W'(p2_left_reg[g]);
        end
        d_next = signed'({1'b0, r_sum}) - signed'({1'b0, l_sum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            p1_valid_reg <= accept && (samples.last_sample || (in_range && is_node));
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p1_last_reg  <= samples.last_sample;
            p1_index_reg <= node_index;
            p1_len_reg   <= len;
            p2_last_reg  <= p1_last_reg;
            p2_index_reg <= p1_index_reg;
            p2_right_reg <= r_grp;
            p2_left_reg  <= l_grp;
            p3_last_reg  <= p2_last_reg;
            p3_index_reg <= p2_index_reg;
            p3_d_reg     <= d_next;
        end
    end

    // compare at full precision against +s and -s
    always_comb
    begin
        ds  = CW'(p3_d_reg);
        ss  = signed'(CW'(s_reg));
        nss = -ss;
        push_flags.is_last = p3_last_reg;
        push_flags.gt_s    = (ds > ss);
        push_flags.ge_s    = (ds >= ss);
        push_flags.lt_negs = (ds < nss);
        push_flags.le_negs = (ds <= nss);
    end

    assign push          = p3_valid_reg && queue_ready;
    assign push_index    = p3_index_reg;
    assign push_strength = p3_d_reg;

endmodule

[src/slep_back.sv]
// ----------------------------------------------------------------------------
// slep_back
// strongest / first edge selection and per-line result register
// ----------------------------------------------------------------------------
module slep_back
    import slep_pkg::*;
#(
    parameter int MAX_HALF_LENGTH = DEF_MAX_HALF_LENGTH,
    parameter int MAX_LINE_NODES  = DEF_MAX_LINE_NODES,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    localparam int IDX_W          = $clog2(MAX_LINE_NODES),
    localparam int DW             = SAMPLE_BITS + $clog2(MAX_HALF_LENGTH + 1) + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 entry_valid,
    input  node_flags_t          entry_flags,
    input  logic [IDX_W-1:0]     entry_index,
    input  logic signed [DW-1:0] entry_strength,
    output logic                 take,
    slep_out_if.source           results
);
    logic signed [DW-1:0] best_reg, best_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 found_reg, found_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [DEPTH_W-1:0]   look_reg, look_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg, out_found_next;
    logic [IDX_W-1:0]             out_index_reg, out_index_next;
    logic signed [STRENGTH_W-1:0] out_strength_reg, out_strength_next;

    logic got, cand, opp;

    assign take = entry_valid
               && (!entry_flags.is_last || !out_valid_reg || results.ready);

    always_comb
    begin
        best_next         = best_reg;
        best_idx_next     = best_idx_reg;
        found_next        = found_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        look_next         = look_reg;
        out_valid_next    = out_valid_reg && !results.ready;
        out_found_next    = out_found_reg;
        out_index_next    = out_index_reg;
        out_strength_next = out_strength_reg;
        got  = found_reg || pend_reg;
        cand = cfg.falling_edge ? entry_flags.lt_negs : entry_flags.gt_s;
        opp  = cfg.falling_edge ? entry_flags.gt_s : entry_flags.lt_negs;
        if (take)
        begin
            if (entry_flags.is_last)
            begin
                out_valid_next    = 1'b1;
                out_found_next    = got;
                out_index_next    = !got ? '0 : (found_reg ? best_idx_reg : pend_idx_reg);
                out_strength_next = got ? STRENGTH_W'(best_reg) : '0;
                best_next         = '0;
                best_idx_next     = '0;
                found_next        = 1'b0;
                pend_next         = 1'b0;
                pend_idx_next     = '0;
                look_next         = '0;
            end
            else if (!cfg.select_first)
            begin
                if (!cfg.falling_edge && entry_strength > best_reg && entry_flags.ge_s)
                begin
                    best_next     = entry_strength;
                    best_idx_next = entry_index;
                    found_next    = 1'b1;
                end
                else if (cfg.falling_edge && entry_strength < best_reg
                         && entry_flags.le_negs)
                begin
                    best_next     = entry_strength;
                    best_idx_next = entry_index;
                    found_next    = 1'b1;
                end
            end
            else if (!found_reg)
            begin
                if (pend_reg)
                begin
                    if (opp)
                    begin
                        pend_next = 1'b0;
                        look_next = '0;
                    end
                    else
                    begin
                        look_next = look_reg - 1'b1;
                        if (look_reg == DEPTH_W'(1))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pend_idx_reg;
                            pend_next     = 1'b0;
                        end
                    end
                end
                else if (cand)
                begin
                    best_next = entry_strength;
                    if (cfg.depth_limit == '0)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = entry_index;
                    end
                    else
                    begin
                        pend_next     = 1'b1;
                        pend_idx_next = entry_index;
                        look_next     = cfg.depth_limit;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            look_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            look_reg      <= look_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg    <= out_found_next;
        out_index_reg    <= out_index_next;
        out_strength_reg <= out_strength_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.found         = out_found_reg;
    assign results.edge_index    = out_index_reg;
    assign results.edge_strength = out_strength_reg;

endmodule
